// ===== sv/pdts_pkg.sv =====
// Package for the priority/deadline task scheduler.
// Holds field widths and operation codes; no dependencies.
`default_nettype none

package pdts_pkg;

   localparam int OP_W   = 3;
   localparam int TASK_W = 5;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 64;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 3'd0,
      OP_READY   = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_UNBLOCK = 3'd4,
      OP_REPRIO  = 3'd5,
      OP_SELECT  = 3'd6,
      OP_WAKE    = 3'd7
   } op_type;

endpackage

`default_nettype wire

// ===== sv/pdts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module pdts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/priority_deadline_task_scheduler.sv =====
// Priority/deadline task scheduler top level; uses pdts_pkg and one pdts_ram record store.
// Select: scans every entry, then compares with the current task if one is given; wake
//   first marks the task ready. Input stalls until the result is in the output register.
// Block/unblock: walk up to NUM_TASKS links, each a read and a scan of the table; moving
//   an existing link walks the old owner's chain first. Remove only clears a ready bit.
// Synchronous reset clears ready, wait and order-valid bits, the order counter and mode.
`default_nettype none

module priority_deadline_task_scheduler #(
   parameter int NUM_TASKS       = 32,
   parameter int PRIORITY_LEVELS = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pdts_pkg::OP_W-1:0]     req_op,
   input  wire logic [pdts_pkg::TASK_W-1:0]   req_task_req,
   input  wire logic [pdts_pkg::TASK_W-1:0]   req_other_task,
   input  wire logic                          req_other_valid,
   input  wire logic [pdts_pkg::PRIO_W-1:0]   req_priority_req,
   input  wire logic [pdts_pkg::TIME_W-1:0]   req_deadline,
   input  wire logic [pdts_pkg::TIME_W-1:0]   req_remaining,
   input  wire logic [pdts_pkg::TIME_W-1:0]   req_run_until,
   input  wire logic [pdts_pkg::TIME_W-1:0]   req_now,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [pdts_pkg::TASK_W-1:0]   rsp_run_task,
   output logic                               rsp_run_valid,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data
);

   import pdts_pkg::*;

   localparam int IW = $clog2(NUM_TASKS);
   localparam int CW = IW + 1;
   localparam int PW = $clog2(PRIORITY_LEVELS);
   localparam logic [PW-1:0] PMAX = PW'(PRIORITY_LEVELS - 1);
   localparam logic [CW-1:0] NCNT = CW'(NUM_TASKS);
   localparam logic [IW-1:0] LAST = IW'(NUM_TASKS - 1);

   typedef struct packed {
      logic [IW-1:0]     waits_on;
      logic [TIME_W-1:0] ready_order;
      logic [TIME_W-1:0] quantum_end;
      logic [TIME_W-1:0] eff_latest_start;
      logic [TIME_W-1:0] eff_deadline;
      logic [TIME_W-1:0] own_remaining;
      logic [TIME_W-1:0] own_deadline;
      logic [PW-1:0]     eff_prio;
      logic [PW-1:0]     base_prio;
   } rec_type;

   localparam int RW = $bits(rec_type);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_RMW_RD   = 13'b0000000000010,
      S_RMW_WR   = 13'b0000000000100,
      S_REL_RD   = 13'b0000000001000,
      S_REL_GET  = 13'b0000000010000,
      S_REC_RD   = 13'b0000000100000,
      S_REC_INIT = 13'b0000001000000,
      S_REC_SCAN = 13'b0000010000000,
      S_REC_UPD  = 13'b0000100000000,
      S_SEL_SCAN = 13'b0001000000000,
      S_CUR_RD   = 13'b0010000000000,
      S_CUR_CMP  = 13'b0100000000000,
      S_OUT      = 13'b1000000000000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [NUM_TASKS-1:0] ready_ff, ready_in;
   logic [NUM_TASKS-1:0] wv_ff, wv_in;
   logic [NUM_TASKS-1:0] ordv_ff, ordv_in;
   logic [TIME_W-1:0]  order_ff, order_in;
   logic               mode_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               link_ff, link_in;

   // payload state
   op_type             op_ff, op_in;
   logic [IW-1:0]      t_ff, t_in;
   logic [IW-1:0]      o_ff, o_in;
   logic               has_cur_ff, has_cur_in;
   logic [PW-1:0]      pri_ff, pri_in;
   logic [TIME_W-1:0]  dl_ff, dl_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0]  ru_ff, ru_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [IW-1:0]      owner_ff, owner_in;
   logic [IW-1:0]      steps_ff, steps_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_v_ff, pend_v_in;
   logic [IW-1:0]      pend_ff, pend_in;
   rec_type            own_ff, own_in;
   logic               bvalid_ff, bvalid_in;
   logic [IW-1:0]      bidx_ff, bidx_in;
   logic [PW-1:0]      bpr_ff, bpr_in;
   logic [TIME_W-1:0]  bdl_ff, bdl_in;
   logic [TIME_W-1:0]  bls_ff, bls_in;
   logic [TIME_W-1:0]  bseq_ff, bseq_in;
   logic [IW-1:0]      res_ff, res_in;
   logic               res_v_ff, res_v_in;
   logic [TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic               rsp_rv_ff, rsp_rv_in;

   // RAM port
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   rec_type            wr_rec;
   logic [IW-1:0]      rd_addr;
   logic [RW-1:0]      rd_raw;
   rec_type            rd_rec;

   logic               t_ok, o_ok;
   logic [IW-1:0]      req_t, req_o;
   logic [PW-1:0]      req_pri;
   logic [TIME_W-1:0]  cand_key, cand_seq, best_key;
   logic               better;

   pdts_ram #(.WIDTH(RW), .DEPTH(NUM_TASKS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_rec = rec_type'(rd_raw);

   assign t_ok    = int'(req_task_req) < NUM_TASKS;
   assign o_ok    = int'(req_other_task) < NUM_TASKS;
   assign req_t   = IW'(req_task_req);
   assign req_o   = IW'(req_other_task);
   assign req_pri = (int'(req_priority_req) > PRIORITY_LEVELS - 1) ? PMAX
                                                                  : PW'(req_priority_req);

   // candidate (entry just read) against running best
   assign cand_key = mode_ff ? rd_rec.eff_latest_start : rd_rec.eff_deadline;
   assign cand_seq = ordv_ff[pend_ff] ? rd_rec.ready_order : '0;
   assign best_key = mode_ff ? bls_ff : bdl_ff;
   assign better   = (rd_rec.eff_prio > bpr_ff) ||
                     ((rd_rec.eff_prio == bpr_ff) &&
                      ((cand_key < best_key) ||
                       ((cand_key == best_key) && (cand_seq < bseq_ff))));

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      wv_in        = wv_ff;
      ordv_in      = ordv_ff;
      order_in     = order_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      link_in      = link_ff;
      op_in        = op_ff;
      t_in         = t_ff;
      o_in         = o_ff;
      has_cur_in   = has_cur_ff;
      pri_in       = pri_ff;
      dl_in        = dl_ff;
      rem_in       = rem_ff;
      ru_in        = ru_ff;
      now_in       = now_ff;
      owner_in     = owner_ff;
      steps_in     = steps_ff;
      scan_in      = scan_ff;
      pend_v_in    = 1'b0;
      pend_in      = pend_ff;
      own_in       = own_ff;
      bvalid_in    = bvalid_ff;
      bidx_in      = bidx_ff;
      bpr_in       = bpr_ff;
      bdl_in       = bdl_ff;
      bls_in       = bls_ff;
      bseq_in      = bseq_ff;
      res_in       = res_ff;
      res_v_in     = res_v_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_rv_in    = rsp_rv_ff;
      wr_en        = 1'b0;
      wr_addr      = t_ff;
      wr_rec       = rd_rec;
      rd_addr      = t_ff;

      // shared table sweep: issue one read per cycle
      if (state_ff == S_REC_SCAN || state_ff == S_SEL_SCAN) begin
         if (scan_ff < NCNT) begin
            rd_addr   = scan_ff[IW-1:0];
            scan_in   = scan_ff + 1'b1;
            pend_v_in = 1'b1;
            pend_in   = scan_ff[IW-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_op);
               t_in       = req_t;
               o_in       = req_o;
               has_cur_in = req_other_valid & o_ok;
               pri_in     = req_pri;
               dl_in      = req_deadline;
               rem_in     = req_remaining;
               ru_in      = req_run_until;
               now_in     = req_now;
               link_in    = 1'b0;
               scan_in    = '0;
               bvalid_in  = 1'b0;
               unique case (op_type'(req_op)) inside
                  OP_LOAD, OP_READY, OP_REPRIO: begin
                     if (t_ok) state_in = S_RMW_RD;
                  end
                  OP_WAKE: begin
                     state_in = t_ok ? S_RMW_RD : S_SEL_SCAN;
                  end
                  OP_REMOVE: begin
                     if (t_ok) ready_in[req_t] = 1'b0;
                  end
                  OP_BLOCK: begin
                     if (t_ok && o_ok) begin
                        ready_in[req_t] = 1'b0;
                        link_in         = 1'b1;
                        state_in        = wv_ff[req_t] ? S_REL_RD : S_RMW_RD;
                     end
                  end
                  OP_UNBLOCK: begin
                     if (t_ok && wv_ff[req_t]) state_in = S_REL_RD;
                  end
                  default: begin
                     state_in = S_SEL_SCAN;
                  end
               endcase
            end
         end

         S_RMW_RD: begin
            rd_addr  = t_ff;
            state_in = S_RMW_WR;
         end

         S_RMW_WR: begin
            wr_en    = 1'b1;
            wr_addr  = t_ff;
            state_in = S_IDLE;
            unique case (op_ff) inside
               OP_LOAD: begin
                  wr_rec.base_prio        = pri_ff;
                  wr_rec.eff_prio         = pri_ff;
                  wr_rec.own_deadline     = dl_ff;
                  wr_rec.own_remaining    = rem_ff;
                  wr_rec.eff_deadline     = dl_ff;
                  wr_rec.eff_latest_start = dl_ff - rem_ff;
                  wr_rec.quantum_end      = ru_ff;
               end
               OP_READY, OP_WAKE: begin
                  wr_rec.ready_order = order_ff;
                  ready_in[t_ff]     = 1'b1;
                  ordv_in[t_ff]      = 1'b1;
                  order_in           = order_ff + 1'b1;
                  if (op_ff == OP_WAKE) begin
                     scan_in   = '0;
                     bvalid_in = 1'b0;
                     state_in  = S_SEL_SCAN;
                  end
               end
               OP_REPRIO: begin
                  wr_rec.eff_prio = pri_ff;
               end
               OP_BLOCK: begin
                  // make the new link, then lend to the new owner
                  wr_rec.waits_on = o_ff;
                  wv_in[t_ff]     = 1'b1;
                  link_in         = 1'b0;
                  owner_in        = o_ff;
                  steps_in        = '0;
                  state_in        = S_REC_RD;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end

         S_REL_RD: begin
            rd_addr  = t_ff;
            state_in = S_REL_GET;
         end

         S_REL_GET: begin
            owner_in    = rd_rec.waits_on;
            wv_in[t_ff] = 1'b0;
            steps_in    = '0;
            state_in    = S_REC_RD;
         end

         S_REC_RD: begin
            rd_addr  = owner_ff;
            state_in = S_REC_INIT;
         end

         S_REC_INIT: begin
            own_in   = rd_rec;
            bpr_in   = rd_rec.base_prio;
            bdl_in   = rd_rec.own_deadline;
            bls_in   = rd_rec.own_deadline - rd_rec.own_remaining;
            bseq_in  = ordv_ff[owner_ff] ? rd_rec.ready_order : '0;
            scan_in  = '0;
            state_in = S_REC_SCAN;
         end

         S_REC_SCAN: begin
            if (pend_v_ff) begin
               if (wv_ff[pend_ff] && rd_rec.waits_on == owner_ff && better) begin
                  bpr_in  = rd_rec.eff_prio;
                  bdl_in  = rd_rec.eff_deadline;
                  bls_in  = rd_rec.eff_latest_start;
                  bseq_in = cand_seq;
               end
               if (pend_ff == LAST) state_in = S_REC_UPD;
            end
         end

         S_REC_UPD: begin
            if (bpr_ff == own_ff.eff_prio && bdl_ff == own_ff.eff_deadline &&
                bls_ff == own_ff.eff_latest_start) begin
               state_in = link_ff ? S_RMW_RD : S_IDLE;
            end else begin
               wr_en                   = 1'b1;
               wr_addr                 = owner_ff;
               wr_rec                  = own_ff;
               wr_rec.eff_prio         = bpr_ff;
               wr_rec.eff_deadline     = bdl_ff;
               wr_rec.eff_latest_start = bls_ff;
               if (!wv_ff[owner_ff] || steps_ff == LAST) begin
                  state_in = link_ff ? S_RMW_RD : S_IDLE;
               end else begin
                  // advance up the blocking chain
                  owner_in = own_ff.waits_on;
                  steps_in = steps_ff + 1'b1;
                  state_in = S_REC_RD;
               end
            end
         end

         S_SEL_SCAN: begin
            if (pend_v_ff) begin
               if (ready_ff[pend_ff] && (!bvalid_ff || better)) begin
                  bvalid_in = 1'b1;
                  bidx_in   = pend_ff;
                  bpr_in    = rd_rec.eff_prio;
                  bdl_in    = rd_rec.eff_deadline;
                  bls_in    = rd_rec.eff_latest_start;
                  bseq_in   = cand_seq;
               end
               if (pend_ff == LAST) state_in = S_CUR_RD;
            end
         end

         S_CUR_RD: begin
            rd_addr = o_ff;
            if (!bvalid_ff) begin
               res_in   = has_cur_ff ? o_ff : '0;
               res_v_in = has_cur_ff;
               state_in = S_OUT;
            end else if (has_cur_ff) begin
               state_in = S_CUR_CMP;
            end else begin
               res_in   = bidx_ff;
               res_v_in = 1'b1;
               state_in = S_OUT;
            end
         end

         S_CUR_CMP: begin
            res_in   = bidx_ff;
            res_v_in = 1'b1;
            if (bpr_ff < rd_rec.eff_prio) begin
               res_in = o_ff;
            end else if (bpr_ff == rd_rec.eff_prio) begin
               // keep current inside its quantum unless latest start is hit
               if (!(mode_ff && now_ff >= bls_ff) && now_ff < rd_rec.quantum_end) begin
                  res_in = o_ff;
               end
            end
            state_in = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = TASK_W'(res_ff);
               rsp_rv_in    = res_v_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= '0;
         wv_ff        <= '0;
         ordv_ff      <= '0;
         order_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         link_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         wv_ff        <= wv_in;
         ordv_ff      <= ordv_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
         link_ff      <= link_in;
         pend_v_ff    <= pend_v_in;
         if (csr_wr_en) mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      t_ff        <= t_in;
      o_ff        <= o_in;
      has_cur_ff  <= has_cur_in;
      pri_ff      <= pri_in;
      dl_ff       <= dl_in;
      rem_ff      <= rem_in;
      ru_ff       <= ru_in;
      now_ff      <= now_in;
      owner_ff    <= owner_in;
      steps_ff    <= steps_in;
      scan_ff     <= scan_in;
      pend_ff     <= pend_in;
      own_ff      <= own_in;
      bvalid_ff   <= bvalid_in;
      bidx_ff     <= bidx_in;
      bpr_ff      <= bpr_in;
      bdl_ff      <= bdl_in;
      bls_ff      <= bls_in;
      bseq_ff     <= bseq_in;
      res_ff      <= res_in;
      res_v_ff    <= res_v_in;
      rsp_task_ff <= rsp_task_in;
      rsp_rv_ff   <= rsp_rv_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_task  = rsp_task_ff;
   assign rsp_run_valid = rsp_rv_ff;

   // a new result only comes from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // an empty result carries task zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rv_ff) |-> (rsp_task_ff == '0))
      else $error("empty result with nonzero task");

   // making a block link sets the wait bit of that task
   a_link_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_WR && op_ff == OP_BLOCK) |=> wv_ff[$past(t_ff)])
      else $error("block link not recorded");

   // a blocked task leaves the ready set at transfer
   a_block_unready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_op == OP_BLOCK && t_ok && o_ok)
      |=> !ready_ff[$past(req_t)])
      else $error("blocked task still ready");

endmodule

`default_nettype wire
